// File: rtl/bsp_pkg.sv
// ----------------------------------------------------------------------------
// bsp_pkg
// Shared types, constants and helper functions of the brush stamp pixel blend
// core: configuration record, stage records and the airbrush falloff table.
// ----------------------------------------------------------------------------
`default_nettype none

package bsp_pkg;

  localparam int CoordBits    = 12;
  localparam int FrameBits    = CoordBits + 1;
  // power of two: the falloff index is a fraction of the squared radius
  localparam int FalloffDepth = 256;
  localparam int IdxBits      = $clog2(FalloffDepth);
  localparam int RadBits      = 12;
  localparam int SqW          = 2 * RadBits;
  localparam int SqW1         = SqW + 1;
  localparam int NumBits      = SqW + IdxBits;
  localparam int GainBits     = 9;

  typedef enum logic [2:0] {
    RegColor  = 3'd0,
    RegAlpha  = 3'd1,
    RegRadius = 3'd2,
    RegKind   = 3'd3,
    RegWidth  = 3'd4,
    RegHeight = 3'd5
  } reg_idx_e;

  typedef enum logic [2:0] {
    KindPencil   = 3'd0,
    KindMarker   = 3'd1,
    KindAirbrush = 3'd2,
    KindEraser   = 3'd3,
    KindDisc     = 3'd4
  } kind_e;

  typedef struct packed {
    logic [23:0]          color;
    logic [7:0]           alpha;
    logic [RadBits-1:0]   radius;
    logic [2:0]           kind;
    logic [FrameBits-1:0] width;
    logic [FrameBits-1:0] height;
  } cfg_t;

  typedef struct packed {
    logic               skip;
    logic [RadBits-1:0] d16;
    logic [31:0]        dest;
  } geo_t;

  typedef struct packed {
    logic        skip;
    logic        erase;
    logic [7:0]  alpha;
    logic [31:0] dest;
  } shd_t;

  typedef struct packed {
    logic [SqW-1:0] rem;
    logic [SqW-1:0] res;
  } sqrt_t;

  // one digit of the bitwise integer square root, digit weight 4**b
  function automatic sqrt_t sqrt_step(sqrt_t s, int b);
    logic [SqW:0] bitv;
    logic [SqW:0] t;
    sqrt_t        o;
    bitv = SqW1'(1) << (2 * b);
    t    = {1'b0, s.res} + bitv;
    o    = s;
    if ({1'b0, s.rem} >= t) begin
      o.rem = s.rem - t[SqW-1:0];
      o.res = (s.res >> 1) + bitv[SqW-1:0];
    end else begin
      o.res = s.res >> 1;
    end
    return o;
  endfunction

  typedef logic [GainBits-1:0] gain_tab_t [FalloffDepth];

  // exp(-3*i/depth) in Q1.8, Q30 series to order 8 on z/8, then squared three times
  function automatic gain_tab_t build_gain_tab();
    gain_tab_t          tab;
    logic [63:0]        z;
    logic [63:0]        term;
    logic [63:0]        e;
    logic signed [63:0] sum;
    for (int i = 0; i < FalloffDepth; i++) begin
      // (3*i << 30) / (8*depth), both powers of two
      z    = (64'd3 * 64'(i)) << (30 - IdxBits - 3);
      sum  = 64'sd1 <<< 30;
      term = 64'd1 << 30;
      term = ((term * z) >> 30) / 64'd1;
      sum  = sum - $signed(term);
      term = ((term * z) >> 30) / 64'd2;
      sum  = sum + $signed(term);
      term = ((term * z) >> 30) / 64'd3;
      sum  = sum - $signed(term);
      term = ((term * z) >> 30) / 64'd4;
      sum  = sum + $signed(term);
      term = ((term * z) >> 30) / 64'd5;
      sum  = sum - $signed(term);
      term = ((term * z) >> 30) / 64'd6;
      sum  = sum + $signed(term);
      term = ((term * z) >> 30) / 64'd7;
      sum  = sum - $signed(term);
      term = ((term * z) >> 30) / 64'd8;
      sum  = sum + $signed(term);
      if (sum < 0) begin
        sum = 64'sd0;
      end
      e = 64'(sum);
      e = (e * e) >> 30;
      e = (e * e) >> 30;
      e = (e * e) >> 30;
      tab[i] = GainBits'((e + (64'd1 << 21)) >> 22);
    end
    return tab;
  endfunction

  localparam gain_tab_t GainTab = build_gain_tab();

endpackage

`default_nettype wire

// File: rtl/bsp_geom.sv
// ----------------------------------------------------------------------------
// bsp_geom
// Frame clipping and distance from the stamp center in Q.4 pixels:
// squares, then a 12-digit square root over four stages.
// ----------------------------------------------------------------------------
`default_nettype none

module bsp_geom (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  logic [bsp_pkg::CoordBits-1:0]       pixel_x_i,
  input  logic [bsp_pkg::CoordBits-1:0]       pixel_y_i,
  input  logic signed [bsp_pkg::CoordBits+1:0] center_x_i,
  input  logic signed [bsp_pkg::CoordBits+1:0] center_y_i,
  input  logic [31:0]                         dest_pixel_i,
  input  bsp_pkg::cfg_t                       cfg_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output bsp_pkg::geo_t                       geo_o
);

  localparam int NumSt      = 5;
  localparam int RootSt     = 4;
  localparam int StepsPerSt = bsp_pkg::RadBits / RootSt;
  localparam int DxBits     = bsp_pkg::CoordBits + 3;
  localparam int SqBits     = 2 * bsp_pkg::CoordBits + 4;
  localparam int NearBits   = bsp_pkg::SqW - 8;

  typedef struct packed {
    logic              skip;
    logic [SqBits-1:0] sqx;
    logic [SqBits-1:0] sqy;
    logic [31:0]       dest;
  } sq_in_t;

  typedef struct packed {
    logic           skip;
    bsp_pkg::sqrt_t sq;
    logic [31:0]    dest;
  } root_t;

  logic [NumSt-1:0]        v_q;
  logic [NumSt-1:0]        en;
  sq_in_t                  p1_d, p1_q;
  root_t                   root_d [RootSt];
  root_t                   root_q [RootSt];
  logic signed [DxBits-1:0]   dx, dy;
  logic signed [2*DxBits-1:0] dxx, dyy;
  logic [SqBits:0]         dsq;

  always_comb begin
    en[NumSt-1] = !v_q[NumSt-1] || ready_i;
    for (int k = NumSt - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[NumSt-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= valid_i;
      end
      for (int k = 1; k < NumSt; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // stage 1: offsets, squares, frame clip
  always_comb begin
    dx = $signed(DxBits'(pixel_x_i)) - DxBits'(center_x_i);
    dy = $signed(DxBits'(pixel_y_i)) - DxBits'(center_y_i);
    dxx = dx * dx;
    dyy = dy * dy;
    p1_d.skip = ({1'b0, pixel_x_i} >= cfg_i.width) || ({1'b0, pixel_y_i} >= cfg_i.height);
    p1_d.sqx  = SqBits'(dxx);
    p1_d.sqy  = SqBits'(dyy);
    p1_d.dest = dest_pixel_i;
  end

  // stages 2..5: square root of dsq*256, three digits per stage
  always_comb begin
    dsq = {1'b0, p1_q.sqx} + {1'b0, p1_q.sqy};
    // beyond the largest radius anyway
    root_d[0].skip   = p1_q.skip || (dsq[SqBits:NearBits] != '0);
    root_d[0].dest   = p1_q.dest;
    root_d[0].sq.rem = {dsq[NearBits-1:0], 8'b0};
    root_d[0].sq.res = '0;
    for (int j = 0; j < StepsPerSt; j++) begin
      root_d[0].sq = bsp_pkg::sqrt_step(root_d[0].sq, bsp_pkg::RadBits - 1 - j);
    end
    for (int k = 1; k < RootSt; k++) begin
      root_d[k] = root_q[k-1];
      for (int j = 0; j < StepsPerSt; j++) begin
        root_d[k].sq = bsp_pkg::sqrt_step(root_d[k].sq,
                                          bsp_pkg::RadBits - 1 - StepsPerSt * k - j);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0] && valid_i) begin
      p1_q <= p1_d;
    end
    for (int k = 0; k < RootSt; k++) begin
      if (en[k+1] && v_q[k]) begin
        root_q[k] <= root_d[k];
      end
    end
  end

  assign geo_o.skip = root_q[RootSt-1].skip;
  assign geo_o.d16  = root_q[RootSt-1].sq.res[bsp_pkg::RadBits-1:0];
  assign geo_o.dest = root_q[RootSt-1].dest;

endmodule

`default_nettype wire

// File: rtl/bsp_shade.sv
// ----------------------------------------------------------------------------
// bsp_shade
// Brush kind handling: disc test, pencil edge, marker ramp, airbrush falloff
// index by restoring division over three stages and table lookup.
// ----------------------------------------------------------------------------
`default_nettype none

module bsp_shade (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  bsp_pkg::geo_t geo_i,
  input  bsp_pkg::cfg_t cfg_i,
  output logic          valid_o,
  input  logic          ready_i,
  output bsp_pkg::shd_t shd_o
);

  localparam int NumSt      = 5;
  localparam int DivSt      = 3;
  localparam int StepsPerSt = (bsp_pkg::IdxBits + 1 + DivSt - 1) / DivSt;

  typedef struct packed {
    logic                         skip;
    logic                         erase;
    logic                         air;
    logic [7:0]                   alpha;
    logic [bsp_pkg::NumBits-1:0]  rem;
    logic [bsp_pkg::SqW-1:0]      dvs;
    logic [bsp_pkg::IdxBits:0]    q;
    logic [31:0]                  dest;
  } sh_t;

  logic [NumSt-1:0]               v_q;
  logic [NumSt-1:0]               en;
  sh_t                            sh0_d;
  sh_t                            sh_d [1:DivSt];
  sh_t                            sh_q [DivSt+1];
  bsp_pkg::shd_t                  out_d, out_q;
  logic [bsp_pkg::RadBits-1:0]    edge_dist;
  logic [11:0]                    mk;
  logic [bsp_pkg::SqW-1:0]        dsq16;
  logic [bsp_pkg::NumBits-1:0]    dsh;
  logic [bsp_pkg::IdxBits-1:0]    idx;
  logic [bsp_pkg::GainBits-1:0]   gain;
  logic [16:0]                    ga;
  int                             bi;

  always_comb begin
    en[NumSt-1] = !v_q[NumSt-1] || ready_i;
    for (int k = NumSt - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[NumSt-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= valid_i;
      end
      for (int k = 1; k < NumSt; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // first stage: kind decode and squares for the falloff index
  always_comb begin
    edge_dist = cfg_i.radius - geo_i.d16;
    mk        = 12'(cfg_i.alpha) * 12'(edge_dist[3:0]);
    dsq16     = bsp_pkg::SqW'(geo_i.d16) * bsp_pkg::SqW'(geo_i.d16);
    sh0_d.skip  = geo_i.skip || (geo_i.d16 > cfg_i.radius);
    sh0_d.erase = 1'b0;
    sh0_d.air   = 1'b0;
    sh0_d.alpha = cfg_i.alpha;
    sh0_d.rem   = {dsq16, bsp_pkg::IdxBits'(0)};
    sh0_d.dvs   = bsp_pkg::SqW'(cfg_i.radius) * bsp_pkg::SqW'(cfg_i.radius);
    sh0_d.q     = '0;
    sh0_d.dest  = geo_i.dest;
    case (cfg_i.kind)
      bsp_pkg::KindPencil: begin
        // hard edge half a pixel inside the radius
        if (({1'b0, geo_i.d16} + 13'd8) > {1'b0, cfg_i.radius}) begin
          sh0_d.skip = 1'b1;
        end
      end
      bsp_pkg::KindMarker: begin
        if (edge_dist < bsp_pkg::RadBits'(16)) begin
          sh0_d.alpha = mk[11:4];
        end
      end
      bsp_pkg::KindAirbrush: begin
        sh0_d.air = 1'b1;
      end
      bsp_pkg::KindEraser: begin
        sh0_d.erase = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // falloff index = d16^2 * depth / r16^2, restoring division
  always_comb begin
    dsh = '0;
    bi  = 0;
    for (int k = 1; k <= DivSt; k++) begin
      sh_d[k] = sh_q[k-1];
      for (int j = 0; j < StepsPerSt; j++) begin
        bi = bsp_pkg::IdxBits - StepsPerSt * (k - 1) - j;
        if (bi >= 0) begin
          dsh = bsp_pkg::NumBits'(sh_d[k].dvs) << bi;
          if (sh_d[k].rem >= dsh) begin
            sh_d[k].rem   = sh_d[k].rem - dsh;
            sh_d[k].q[bi] = 1'b1;
          end
        end
      end
    end
  end

  // last stage: clamp, table, final alpha
  always_comb begin
    if (cfg_i.radius == '0) begin
      idx = '0;
    end else if (sh_q[DivSt].q[bsp_pkg::IdxBits]) begin
      idx = '1;
    end else begin
      idx = sh_q[DivSt].q[bsp_pkg::IdxBits-1:0];
    end
    gain = bsp_pkg::GainTab[idx];
    ga   = 17'(cfg_i.alpha) * 17'(gain);
    out_d.skip  = sh_q[DivSt].skip;
    out_d.erase = sh_q[DivSt].erase;
    out_d.alpha = sh_q[DivSt].air ? ga[15:8] : sh_q[DivSt].alpha;
    out_d.dest  = sh_q[DivSt].dest;
  end

  always_ff @(posedge clk_i) begin
    if (en[0] && valid_i) begin
      sh_q[0] <= sh0_d;
    end
    for (int k = 1; k <= DivSt; k++) begin
      if (en[k] && v_q[k-1]) begin
        sh_q[k] <= sh_d[k];
      end
    end
    if (en[NumSt-1] && v_q[NumSt-2]) begin
      out_q <= out_d;
    end
  end

  assign shd_o = out_q;

endmodule

`default_nettype wire

// File: rtl/bsp_blend.sv
// ----------------------------------------------------------------------------
// bsp_blend
// Source-over composite of the brush color onto the stored pixel: weights,
// numerators, two stages of color division and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bsp_blend (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  bsp_pkg::shd_t shd_i,
  input  bsp_pkg::cfg_t cfg_i,
  output logic          valid_o,
  input  logic          ready_i,
  output logic [31:0]   new_pixel_o,
  output logic          write_pixel_o
);

  localparam int NumSt      = 5;
  localparam int DivSt      = 2;
  localparam int StepsPerSt = 4;

  typedef struct packed {
    logic        skip;
    logic        erase;
    logic [15:0] sw;
    logic [15:0] dw;
    logic [31:0] dest;
  } wt_t;

  typedef struct packed {
    logic            skip;
    logic            erase;
    logic [15:0]     den;
    logic [7:0]      outa;
    logic [2:0][23:0] rem;
    logic [2:0][7:0]  q;
    logic [31:0]     dest;
  } bl_t;

  logic [NumSt-1:0] v_q;
  logic [NumSt-1:0] en;
  wt_t              wt_d, wt_q;
  bl_t              bl0_d;
  bl_t              bl_d [1:DivSt];
  bl_t              bl_q [DivSt+1];
  logic [16:0]      den_sum;
  logic [16:0]      outa_sum;
  logic [23:0]      dsh;
  logic [31:0]      pix_d;
  logic [31:0]      pix_q;
  logic             wr_q;
  int               bi;

  always_comb begin
    en[NumSt-1] = !v_q[NumSt-1] || ready_i;
    for (int k = NumSt - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[NumSt-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= valid_i;
      end
      for (int k = 1; k < NumSt; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // source and destination weights
  always_comb begin
    wt_d.skip  = shd_i.skip || (!shd_i.erase && (shd_i.alpha == 8'd0));
    wt_d.erase = shd_i.erase;
    wt_d.sw    = 16'(shd_i.alpha) * 16'd255;
    wt_d.dw    = 16'(shd_i.dest[31:24]) * 16'(8'd255 - shd_i.alpha);
    wt_d.dest  = shd_i.dest;
  end

  // denominator, output alpha, per-channel numerators
  always_comb begin
    den_sum  = {1'b0, wt_q.sw} + {1'b0, wt_q.dw};
    bl0_d.skip  = wt_q.skip;
    bl0_d.erase = wt_q.erase;
    bl0_d.den   = den_sum[15:0];
    // exact floor of den/255 for 16-bit den
    outa_sum = {1'b0, den_sum[15:0]} + 17'd1 + 17'(den_sum[15:8]);
    bl0_d.outa  = outa_sum[15:8];
    bl0_d.q     = '0;
    bl0_d.dest  = wt_q.dest;
    for (int c = 0; c < 3; c++) begin
      bl0_d.rem[c] = 24'(cfg_i.color[8*(2-c) +: 8]) * 24'(wt_q.sw)
                   + 24'(wt_q.dest[8*c +: 8]) * 24'(wt_q.dw);
    end
  end

  // color quotients, at most 255 since each is a weighted average
  always_comb begin
    dsh = '0;
    bi  = 0;
    for (int k = 1; k <= DivSt; k++) begin
      bl_d[k] = bl_q[k-1];
      for (int j = 0; j < StepsPerSt; j++) begin
        bi  = 7 - StepsPerSt * (k - 1) - j;
        dsh = 24'(bl_d[k].den) << bi;
        for (int c = 0; c < 3; c++) begin
          if (bl_d[k].rem[c] >= dsh) begin
            bl_d[k].rem[c]   = bl_d[k].rem[c] - dsh;
            bl_d[k].q[c][bi] = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    if (bl_q[DivSt].skip) begin
      pix_d = bl_q[DivSt].dest;
    end else if (bl_q[DivSt].erase) begin
      pix_d = '0;
    end else if (bl_q[DivSt].den == '0) begin
      pix_d = {bl_q[DivSt].outa, 24'd0};
    end else begin
      pix_d = {bl_q[DivSt].outa, bl_q[DivSt].q[2], bl_q[DivSt].q[1], bl_q[DivSt].q[0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0] && valid_i) begin
      wt_q <= wt_d;
    end
    if (en[1] && v_q[0]) begin
      bl_q[0] <= bl0_d;
    end
    for (int k = 1; k <= DivSt; k++) begin
      if (en[k+1] && v_q[k]) begin
        bl_q[k] <= bl_d[k];
      end
    end
    if (en[NumSt-1] && v_q[NumSt-2]) begin
      pix_q <= pix_d;
      wr_q  <= !bl_q[DivSt].skip;
    end
  end

  assign new_pixel_o   = pix_q;
  assign write_pixel_o = wr_q;

endmodule

`default_nettype wire

// File: rtl/brush_stamp_pixel_blend_core.sv
// ----------------------------------------------------------------------------
// brush_stamp_pixel_blend_core
// Shades one framebuffer pixel per item under a round brush stamp and
// composites the brush color source-over onto the stored pixel.
// ----------------------------------------------------------------------------
// Fully pipelined: one item per clock through 15 register stages while no
// back pressure holds the output; the last stage is the result register. The
// depth comes from the 12-digit distance square root (four stages), the 9-bit
// airbrush falloff division (three stages) and the 8-bit color division (two
// stages). Each stage holds its item under back pressure and bubbles close up,
// so the input keeps accepting while earlier results wait, until every stage
// holds an item. Brush registers are read live; write them between strokes.
`default_nettype none

module brush_stamp_pixel_blend_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [2:0]                           cfg_idx_i,
  input  logic [23:0]                          cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [bsp_pkg::CoordBits-1:0]        pixel_x_i,
  input  logic [bsp_pkg::CoordBits-1:0]        pixel_y_i,
  input  logic signed [bsp_pkg::CoordBits+1:0] center_x_i,
  input  logic signed [bsp_pkg::CoordBits+1:0] center_y_i,
  input  logic [31:0]                          dest_pixel_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [31:0]                          new_pixel_o,
  output logic                                 write_pixel_o
);

  bsp_pkg::cfg_t cfg_q;
  bsp_pkg::geo_t geo;
  bsp_pkg::shd_t shd;
  logic          geo_valid, geo_ready;
  logic          shd_valid, shd_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.color  <= 24'd0;
      cfg_q.alpha  <= 8'd255;
      cfg_q.radius <= bsp_pkg::RadBits'(16);
      cfg_q.kind   <= bsp_pkg::KindPencil;
      cfg_q.width  <= bsp_pkg::FrameBits'(4096);
      cfg_q.height <= bsp_pkg::FrameBits'(4096);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bsp_pkg::RegColor:  cfg_q.color  <= cfg_data_i;
        bsp_pkg::RegAlpha:  cfg_q.alpha  <= cfg_data_i[7:0];
        bsp_pkg::RegRadius: cfg_q.radius <= cfg_data_i[bsp_pkg::RadBits-1:0];
        bsp_pkg::RegKind:   cfg_q.kind   <= cfg_data_i[2:0];
        bsp_pkg::RegWidth:  cfg_q.width  <= cfg_data_i[bsp_pkg::FrameBits-1:0];
        bsp_pkg::RegHeight: cfg_q.height <= cfg_data_i[bsp_pkg::FrameBits-1:0];
        default: begin
        end
      endcase
    end
  end

  bsp_geom u_geom (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (in_valid_i),
    .ready_o      (in_ready_o),
    .pixel_x_i    (pixel_x_i),
    .pixel_y_i    (pixel_y_i),
    .center_x_i   (center_x_i),
    .center_y_i   (center_y_i),
    .dest_pixel_i (dest_pixel_i),
    .cfg_i        (cfg_q),
    .valid_o      (geo_valid),
    .ready_i      (geo_ready),
    .geo_o        (geo)
  );

  bsp_shade u_shade (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (geo_valid),
    .ready_o (geo_ready),
    .geo_i   (geo),
    .cfg_i   (cfg_q),
    .valid_o (shd_valid),
    .ready_i (shd_ready),
    .shd_o   (shd)
  );

  bsp_blend u_blend (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (shd_valid),
    .ready_o       (shd_ready),
    .shd_i         (shd),
    .cfg_i         (cfg_q),
    .valid_o       (out_valid_o),
    .ready_i       (out_ready_i),
    .new_pixel_o   (new_pixel_o),
    .write_pixel_o (write_pixel_o)
  );

endmodule

`default_nettype wire
